### sv/efs_pkg.sv
`timescale 1ns / 1ps

package efs_pkg;

    localparam int FLOOR_W     = 5;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 3;
    // wide enough to compare a floor number against any FLOORS up to 64
    localparam int FLOOR_CMP_W = 7;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    localparam logic [FUNC_W-1:0] FN_PRESS = 2'd0;
    localparam logic [FUNC_W-1:0] FN_CALL  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_RUN   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_PENDING = 3'd1,
        ST_CURRENT = 3'd2,
        ST_ARRIVED = 3'd3,
        ST_IDLE    = 3'd4
    } t_status;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [FLOOR_W-1:0] floor;
        logic               dir_up;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [FLOOR_W-1:0] car_floor;
        logic               heading_up;
        logic               last;
    } t_rsp;

    typedef struct packed {
        logic capture;   // latch the accepted transaction
        logic single;    // produce the one result of a press, call or empty run
        logic step;      // serve one floor of a run
        logic last;      // mark the step result as final
    } t_dp_cmd;

    typedef struct packed {
        logic run_work;  // buffered item is a run with floors pending
        logic one_left;  // the floor picked now is the last one pending
    } t_dp_stat;

endpackage

### sv/efs_channels.sv
`timescale 1ns / 1ps

interface efs_req_if import efs_pkg::*;;
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface efs_rsp_if import efs_pkg::*;;
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/efs_ctrl.sv
`timescale 1ns / 1ps

module efs_ctrl import efs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    output logic     o_rsp_valid,
    input  logic     i_rsp_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state             r_state, n_state;
    logic               r_buf_valid, n_buf_valid;
    logic               r_out_valid, n_out_valid;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               slot_free;
    logic               accept;
    logic               step_last;

    assign slot_free   = !r_out_valid || i_rsp_ready;
    assign o_req_ready = !r_buf_valid;
    assign accept      = i_req_valid && !r_buf_valid;
    assign step_last   = i_stat.one_left || (r_count == CNT_W'(MAX_RESULTS - 1));
    assign o_rsp_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_buf_valid  = r_buf_valid;
        n_out_valid  = r_out_valid && !i_rsp_ready;
        n_count      = r_count;
        o_cmd        = '0;
        o_cmd.capture = accept;
        o_cmd.last    = step_last;
        unique case (r_state)
            S_IDLE: begin
                if (r_buf_valid && slot_free) begin
                    n_buf_valid = 1'b0;
                    if (i_stat.run_work) begin
                        n_state = S_RUN;
                        n_count = '0;
                    end else begin
                        o_cmd.single = 1'b1;
                        n_out_valid  = 1'b1;
                    end
                end
            end
            S_RUN: begin
                if (slot_free) begin
                    o_cmd.step  = 1'b1;
                    n_out_valid = 1'b1;
                    n_count     = r_count + CNT_W'(1);
                    if (step_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (accept) begin
            n_buf_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_buf_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_buf_valid <= n_buf_valid;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

endmodule

### sv/efs_datapath.sv
`timescale 1ns / 1ps

module efs_datapath import efs_pkg::*; #(
    parameter int FLOORS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_req     i_req_data,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    output t_rsp     o_rsp_data
);

    localparam logic [FLOOR_CMP_W-1:0] FLOORS_V = FLOOR_CMP_W'(FLOORS);

    t_req               r_item;
    t_rsp               r_out;
    logic [FLOOR_W-1:0] r_car;
    logic               r_up;
    logic [FLOORS-1:0]  r_pend;

    logic [FLOOR_CMP_W-1:0] item_fl_w, car_w, pick_num;
    logic [FLOORS-1:0]      fl_mask, car_mask, above, below;
    logic [FLOORS-1:0]      ahead_up, ahead_dn, ahead_dn_rev;
    logic [FLOORS-1:0]      low_up, low_dn_rev, high_dn, pick;
    logic                   fl_valid, fl_pend, here;
    logic                   pick_up;

    // single result
    t_rsp               single_rsp;
    logic [FLOORS-1:0]  single_pend;
    logic [FLOOR_W-1:0] single_car;
    logic               single_up;

    assign item_fl_w = FLOOR_CMP_W'(r_item.floor);
    assign car_w     = FLOOR_CMP_W'(r_car);
    assign fl_valid  = (r_item.floor != '0) && (item_fl_w <= FLOORS_V);

    always_comb begin
        for (int i = 0; i < FLOORS; i++) begin
            fl_mask[i]  = (item_fl_w == FLOOR_CMP_W'(i + 1));
            car_mask[i] = (car_w == FLOOR_CMP_W'(i + 1));
            above[i]    = (car_w < FLOOR_CMP_W'(i + 1));
            below[i]    = (car_w > FLOOR_CMP_W'(i + 1));
        end
    end

    assign fl_pend  = |(r_pend & fl_mask);
    assign here     = |(r_pend & car_mask);
    assign ahead_up = r_pend & above;
    assign ahead_dn = r_pend & below;

    // nearest above: lowest set bit; nearest below: highest set bit via reversal
    always_comb begin
        for (int i = 0; i < FLOORS; i++) begin
            ahead_dn_rev[i] = ahead_dn[FLOORS-1-i];
        end
    end

    assign low_up     = ahead_up & (~ahead_up + FLOORS'(1));
    assign low_dn_rev = ahead_dn_rev & (~ahead_dn_rev + FLOORS'(1));

    always_comb begin
        for (int i = 0; i < FLOORS; i++) begin
            high_dn[i] = low_dn_rev[FLOORS-1-i];
        end
    end

    // LOOK choice: current floor, then ahead in the heading, then the far side
    always_comb begin
        pick    = car_mask;
        pick_up = r_up;
        if (!here) begin
            if (r_up) begin
                if (ahead_up != '0) begin
                    pick = low_up;
                end else begin
                    pick    = high_dn;
                    pick_up = 1'b0;
                end
            end else begin
                if (ahead_dn != '0) begin
                    pick = high_dn;
                end else begin
                    pick    = low_up;
                    pick_up = 1'b1;
                end
            end
        end
    end

    always_comb begin
        pick_num = '0;
        for (int i = 0; i < FLOORS; i++) begin
            pick_num = pick_num | (pick[i] ? FLOOR_CMP_W'(i + 1) : '0);
        end
    end

    always_comb begin
        single_pend = r_pend;
        single_car  = r_car;
        single_up   = r_up;
        single_rsp.status = ST_IDLE;
        case (r_item.func)
            FN_PRESS: begin
                if (!fl_valid) begin
                    single_rsp.status = ST_IDLE;
                end else if (r_item.floor == r_car) begin
                    single_rsp.status = ST_CURRENT;
                end else if (fl_pend) begin
                    single_rsp.status = ST_PENDING;
                end else begin
                    single_pend       = r_pend | fl_mask;
                    single_rsp.status = ST_ADDED;
                end
            end
            FN_CALL: begin
                if (fl_valid) begin
                    single_car        = r_item.floor;
                    single_up         = r_item.dir_up;
                    single_rsp.status = ST_ARRIVED;
                end
            end
            default: single_rsp.status = ST_IDLE;
        endcase
        single_rsp.car_floor  = single_car;
        single_rsp.heading_up = single_up;
        single_rsp.last       = 1'b1;
    end

    assign o_stat.run_work = (r_item.func == FN_RUN) && (r_pend != '0);
    assign o_stat.one_left = ((r_pend & ~pick) == '0);
    assign o_rsp_data      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car  <= FLOOR_W'(1);
            r_up   <= 1'b1;
            r_pend <= '0;
        end else if (i_cmd.single) begin
            r_car  <= single_car;
            r_up   <= single_up;
            r_pend <= single_pend;
        end else if (i_cmd.step) begin
            r_car  <= pick_num[FLOOR_W-1:0];
            r_up   <= pick_up;
            r_pend <= r_pend & ~pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_req_data;
        end
        if (i_cmd.single) begin
            r_out <= single_rsp;
        end else if (i_cmd.step) begin
            r_out.status     <= ST_ARRIVED;
            r_out.car_floor  <= pick_num[FLOOR_W-1:0];
            r_out.heading_up <= pick_up;
            r_out.last       <= i_cmd.last;
        end
    end

endmodule

### sv/elevator_floor_scheduler_core.sv
`timescale 1ns / 1ps

// Elevator floor scheduler: car floor, heading and a bitmap of pending floors.
// i_req (sink) carries one transaction per command: func (press, call, run),
// floor and dir_up. o_rsp (source) carries status, car_floor, heading_up and
// last. A press or a call gives one result; a run gives one arrival per
// pending floor in LOOK order (current floor first, then floors ahead,
// nearest first, then the far side), at most 16, with last on the final
// one, or one idle result. An accepted transaction sits in a one-entry
// input buffer; its single result is loaded into the output register
// straight from the buffer, while a run first moves the controller into its
// run state and then loads its first arrival; each load waits until that
// register is free.
// Throughput: one arrival per cycle in a run while the receiver takes each
// result; the LOOK pick over the bitmap is combinational.
// The input buffer takes the next transaction while a result waits in the
// output register. When the receiver stalls, hold the result, hold the run
// where it is, and stop accepting once the buffer is full.
// Reset (synchronous, active low): car at floor 1, heading up, nothing
// pending, no result shown, buffer empty.

module elevator_floor_scheduler_core import efs_pkg::*; #(
    parameter int FLOORS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    efs_req_if.sink   i_req,
    efs_rsp_if.source o_rsp
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // controller: buffer handshake, run sequencing, output valid
    efs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath: car state, pending bitmap, LOOK pick, result register
    efs_datapath #(
        .FLOORS (FLOORS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_data (i_req.data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_rsp_data (o_rsp.data)
    );

endmodule

### sv/efs_checker.sv
`timescale 1ns / 1ps

module efs_checker import efs_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp_data
);

    // a shown result holds until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_data)))
        else $error("result dropped or changed while stalled");

    // only arrival results may leave last low
    a_last_only_arrival: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_data.status != ST_ARRIVED) |-> i_rsp_data.last)
        else $error("non-arrival result without last");

    // a shown result never reports the car at floor zero
    a_car_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_data.car_floor != '0))
        else $error("car floor zero");

    // reset clears the output
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result shown after reset");

endmodule

bind elevator_floor_scheduler_core efs_checker u_efs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);
